// ===== src/fasp_pkg.sv =====
// ----------------------------------------------------------------------------
// fasp_pkg
// Shared types, constants and the arctangent table for the fin angle to
// servo pulse core.
// ----------------------------------------------------------------------------
package fasp_pkg;

   localparam int CORDIC_STEPS    = 16;
   localparam int ANGLE_FRAC_BITS = 8;

   localparam int TABLE_FRAC    = 16;
   localparam int PRESCALE_BITS = 14;
   localparam int LANES         = 4;
   localparam int IN_W          = 16;
   localparam int VEC_W         = IN_W + 1;
   localparam int XY_W          = 33;
   localparam int ACC_W         = 27;
   localparam int STEP_W        = 5;
   localparam int TICK_W        = 16;
   localparam int SPAN_W        = TICK_W + 1;
   localparam int ROUND_SHIFT   = TABLE_FRAC - ANGLE_FRAC_BITS;
   localparam int ANG_W         = ANGLE_FRAC_BITS + 10;
   localparam int T_W           = ANGLE_FRAC_BITS + 9;
   localparam int PROD_W        = SPAN_W + T_W;
   localparam int DIV_SHIFT     = ANGLE_FRAC_BITS + 2;
   localparam int Q_W           = 23;
   localparam int RECIP_W       = 24;
   localparam int RECIP_SHIFT   = 29;
   localparam int MAP_PROD_W    = Q_W + RECIP_W;
   localparam int PIPE_DEPTH    = CORDIC_STEPS + 3;
   localparam int CNT_W         = 6;

   localparam logic signed [ACC_W-1:0] ACC_LIM =
      ACC_W'(90 * (1 << TABLE_FRAC));
   localparam logic signed [ACC_W-1:0] ACC_HALF_TURN =
      ACC_W'(180 * (1 << TABLE_FRAC));
   localparam logic signed [ACC_W-1:0] ROUND_HALF =
      ACC_W'(1 << (ROUND_SHIFT - 1));
   localparam logic signed [ANG_W-1:0] ANG_90 = ANG_W'(90 * (1 << ANGLE_FRAC_BITS));
   localparam logic signed [ANG_W-1:0] ANG_70 = ANG_W'(70 * (1 << ANGLE_FRAC_BITS));
   // floor(p / (180 * 2^F)) = floor(floor(p / 2^(F+2)) / 45), offset keeps it positive
   localparam logic signed [PROD_W-1:0] Q_OFFSET = PROD_W'(45 * (1 << TICK_W));
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((1 << RECIP_SHIFT) + 44) / 45);

   localparam logic [0:0] CSR_MIN_PULSE = 1'b0;
   localparam logic [0:0] CSR_MAX_PULSE = 1'b1;

   localparam logic [TICK_W-1:0] MIN_PULSE_RESET = 16'd1500;
   localparam logic [TICK_W-1:0] MAX_PULSE_RESET = 16'd6000;

   typedef struct packed {
      logic signed [IN_W-1:0] x_value;
      logic signed [IN_W-1:0] y_value;
   } req_type;

   typedef struct packed {
      logic [TICK_W-1:0] fin_a_ticks;
      logic [TICK_W-1:0] fin_b_ticks;
      logic [TICK_W-1:0] fin_c_ticks;
      logic [TICK_W-1:0] fin_d_ticks;
   } rsp_type;

   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [ACC_W-1:0] acc;
      logic signed [1:0]       quad;
      logic                    zero;
   } lane_type;

   typedef lane_type [LANES-1:0] lanes_type;

   // atan(2^-i) in degrees, Q16
   function automatic logic signed [ACC_W-1:0] atan_q16(input logic [STEP_W-1:0] idx);
      logic signed [ACC_W-1:0] v;
      case (idx)
         5'd0:    v = ACC_W'(2949120);
         5'd1:    v = ACC_W'(1740967);
         5'd2:    v = ACC_W'(919879);
         5'd3:    v = ACC_W'(466945);
         5'd4:    v = ACC_W'(234379);
         5'd5:    v = ACC_W'(117265);
         5'd6:    v = ACC_W'(58666);
         5'd7:    v = ACC_W'(29335);
         5'd8:    v = ACC_W'(14668);
         5'd9:    v = ACC_W'(7334);
         5'd10:   v = ACC_W'(3667);
         5'd11:   v = ACC_W'(1833);
         5'd12:   v = ACC_W'(917);
         5'd13:   v = ACC_W'(458);
         5'd14:   v = ACC_W'(229);
         5'd15:   v = ACC_W'(115);
         5'd16:   v = ACC_W'(57);
         5'd17:   v = ACC_W'(29);
         5'd18:   v = ACC_W'(14);
         5'd19:   v = ACC_W'(7);
         5'd20:   v = ACC_W'(4);
         5'd21:   v = ACC_W'(2);
         5'd22:   v = ACC_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== src/fin_angle_to_servo_pulse_core.sv =====
// ----------------------------------------------------------------------------
// fin_angle_to_servo_pulse_core
// Four-fin servo pulse mapper: CORDIC atan2 of four rotated copies of one
// direction vector, clamped and scaled between two pulse-width registers.
// ----------------------------------------------------------------------------
//   channel | ports                      | payload
//   --------+----------------------------+------------------------------
//   input   | req_valid, req_ready       | req_data  (x_value, y_value)
//   result  | rsp_valid, rsp_ready       | rsp_data  (fin_a..fin_d ticks)
//   config  | csr_valid, csr_ready       | csr_index, csr_data
//
// One transaction per cycle while the result side is not stalled; the path
// runs through the chain of CORDIC cells followed by three mapping stages.
// Synchronous reset empties every stage and loads the pulse registers with
// their defaults; no clearing pass. A stalled result holds the full stages
// behind it, up to the first bubble; the rest keep taking transactions.
// ----------------------------------------------------------------------------
module fin_angle_to_servo_pulse_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  fasp_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output fasp_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [0:0]                    csr_index,
   input  logic [fasp_pkg::TICK_W-1:0]   csr_data
);

   logic [fasp_pkg::TICK_W-1:0] min_ticks_ff;
   logic [fasp_pkg::TICK_W-1:0] max_ticks_ff;

   logic signed [fasp_pkg::VEC_W-1:0] vx;
   logic signed [fasp_pkg::VEC_W-1:0] vy;
   logic signed [fasp_pkg::VEC_W-1:0] nx;
   logic signed [fasp_pkg::VEC_W-1:0] ny;

   fasp_pkg::lanes_type               chain_lanes [fasp_pkg::CORDIC_STEPS+1];
   logic [fasp_pkg::CORDIC_STEPS:0]   chain_valid;
   logic [fasp_pkg::CORDIC_STEPS:0]   chain_ready;

   function automatic fasp_pkg::lane_type make_lane(
      input logic signed [fasp_pkg::VEC_W-1:0] px,
      input logic signed [fasp_pkg::VEC_W-1:0] py
   );
      fasp_pkg::lane_type               ln;
      logic signed [fasp_pkg::XY_W-1:0] xs;
      logic signed [fasp_pkg::XY_W-1:0] ys;
      xs      = fasp_pkg::XY_W'(px) <<< fasp_pkg::PRESCALE_BITS;
      ys      = fasp_pkg::XY_W'(py) <<< fasp_pkg::PRESCALE_BITS;
      ln.acc  = '0;
      ln.zero = (px == '0) && (py == '0);
      if (px[fasp_pkg::VEC_W-1]) begin
         ln.quad = py[fasp_pkg::VEC_W-1] ? 2'sb11 : 2'sb01;
         ln.x    = -xs;
         ln.y    = -ys;
      end else begin
         ln.quad = 2'sb00;
         ln.x    = xs;
         ln.y    = ys;
      end
      return ln;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ticks_ff <= fasp_pkg::MIN_PULSE_RESET;
         max_ticks_ff <= fasp_pkg::MAX_PULSE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            fasp_pkg::CSR_MIN_PULSE: min_ticks_ff <= csr_data;
            fasp_pkg::CSR_MAX_PULSE: max_ticks_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign vx = fasp_pkg::VEC_W'(req_data.x_value);
   assign vy = fasp_pkg::VEC_W'(req_data.y_value);
   assign nx = -vx;
   assign ny = -vy;

   assign chain_lanes[0][0] = make_lane(vx, vy);
   assign chain_lanes[0][1] = make_lane(ny, vx);
   assign chain_lanes[0][2] = make_lane(nx, ny);
   assign chain_lanes[0][3] = make_lane(vy, nx);
   assign chain_valid[0]    = req_valid;
   assign req_ready         = chain_ready[0];

   for (genvar g = 0; g < fasp_pkg::CORDIC_STEPS; g++) begin : g_cell
      fasp_cordic_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .step_idx   (fasp_pkg::STEP_W'(g)),
         .up_valid   (chain_valid[g]),
         .up_ready   (chain_ready[g]),
         .up_lanes   (chain_lanes[g]),
         .down_valid (chain_valid[g+1]),
         .down_ready (chain_ready[g+1]),
         .down_lanes (chain_lanes[g+1])
      );
   end

   fasp_pulse_map u_map (
      .clock      (clock),
      .reset      (reset),
      .min_ticks  (min_ticks_ff),
      .max_ticks  (max_ticks_ff),
      .up_valid   (chain_valid[fasp_pkg::CORDIC_STEPS]),
      .up_ready   (chain_ready[fasp_pkg::CORDIC_STEPS]),
      .up_lanes   (chain_lanes[fasp_pkg::CORDIC_STEPS]),
      .down_valid (rsp_valid),
      .down_ready (rsp_ready),
      .down_data  (rsp_data)
   );

endmodule

// ===== src/fasp_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// fasp_cordic_cell
// One vectoring CORDIC iteration for all four fin vectors, with its own
// pipeline register and valid/ready hand-off to the next cell.
// ----------------------------------------------------------------------------
module fasp_cordic_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [fasp_pkg::STEP_W-1:0]   step_idx,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  fasp_pkg::lanes_type           up_lanes,
   output logic                          down_valid,
   input  logic                          down_ready,
   output fasp_pkg::lanes_type           down_lanes
);

   logic                              valid_ff;
   logic                              valid_in;
   fasp_pkg::lanes_type               lanes_ff;
   fasp_pkg::lanes_type               lanes_in;
   logic signed [fasp_pkg::XY_W-1:0]  dx [fasp_pkg::LANES];
   logic signed [fasp_pkg::XY_W-1:0]  dy [fasp_pkg::LANES];
   logic signed [fasp_pkg::ACC_W-1:0] angle_step;

   assign up_ready   = !valid_ff || down_ready;
   assign valid_in   = up_ready ? up_valid : valid_ff;
   assign down_valid = valid_ff;
   assign down_lanes = lanes_ff;
   assign angle_step = fasp_pkg::atan_q16(step_idx);

   always_comb begin
      lanes_in = up_lanes;
      for (int l = 0; l < fasp_pkg::LANES; l++) begin
         dx[l] = $signed(up_lanes[l].y) >>> step_idx;
         dy[l] = $signed(up_lanes[l].x) >>> step_idx;
         if (!up_lanes[l].y[fasp_pkg::XY_W-1]) begin
            lanes_in[l].x   = up_lanes[l].x + dx[l];
            lanes_in[l].y   = up_lanes[l].y - dy[l];
            lanes_in[l].acc = up_lanes[l].acc + angle_step;
         end else begin
            lanes_in[l].x   = up_lanes[l].x - dx[l];
            lanes_in[l].y   = up_lanes[l].y + dy[l];
            lanes_in[l].acc = up_lanes[l].acc - angle_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         lanes_ff <= lanes_in;
      end
   end

endmodule

// ===== src/fasp_pulse_map.sv =====
// ----------------------------------------------------------------------------
// fasp_pulse_map
// Rounds and clamps the four CORDIC angles and maps them onto pulse widths
// in three stages: span multiply, reciprocal divide by 45, offset add. The
// last stage is the result register.
// ----------------------------------------------------------------------------
module fasp_pulse_map (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [fasp_pkg::TICK_W-1:0]   min_ticks,
   input  logic [fasp_pkg::TICK_W-1:0]   max_ticks,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  fasp_pkg::lanes_type           up_lanes,
   output logic                          down_valid,
   input  logic                          down_ready,
   output fasp_pkg::rsp_type             down_data
);

   logic [2:0] valid_ff;
   logic [2:0] valid_in;
   logic [2:0] stage_ready;

   logic signed [fasp_pkg::SPAN_W-1:0]   span;
   logic signed [fasp_pkg::ACC_W-1:0]    acc_c   [fasp_pkg::LANES];
   logic signed [fasp_pkg::ACC_W-1:0]    z_full  [fasp_pkg::LANES];
   logic signed [fasp_pkg::ACC_W-1:0]    z_round [fasp_pkg::LANES];
   logic signed [fasp_pkg::ANG_W-1:0]    ang     [fasp_pkg::LANES];
   logic signed [fasp_pkg::ANG_W-1:0]    ang_c   [fasp_pkg::LANES];
   logic signed [fasp_pkg::ANG_W-1:0]    t_wide  [fasp_pkg::LANES];
   logic signed [fasp_pkg::T_W-1:0]      t_val   [fasp_pkg::LANES];
   logic signed [fasp_pkg::PROD_W-1:0]   prod_in [fasp_pkg::LANES];
   logic signed [fasp_pkg::PROD_W-1:0]   prod_ff [fasp_pkg::LANES];
   logic signed [fasp_pkg::PROD_W-1:0]   q_sum   [fasp_pkg::LANES];
   logic [fasp_pkg::Q_W-1:0]             q_val   [fasp_pkg::LANES];
   logic [fasp_pkg::MAP_PROD_W-1:0]      div_in  [fasp_pkg::LANES];
   logic [fasp_pkg::MAP_PROD_W-1:0]      div_ff  [fasp_pkg::LANES];
   logic [fasp_pkg::TICK_W-1:0]          ticks   [fasp_pkg::LANES];
   fasp_pkg::rsp_type                    rsp_in;
   fasp_pkg::rsp_type                    rsp_ff;

   assign stage_ready[2] = !valid_ff[2] || down_ready;
   assign stage_ready[1] = !valid_ff[1] || stage_ready[2];
   assign stage_ready[0] = !valid_ff[0] || stage_ready[1];
   assign up_ready       = stage_ready[0];

   assign valid_in[0] = stage_ready[0] ? up_valid    : valid_ff[0];
   assign valid_in[1] = stage_ready[1] ? valid_ff[0] : valid_ff[1];
   assign valid_in[2] = stage_ready[2] ? valid_ff[1] : valid_ff[2];

   assign down_valid = valid_ff[2];
   assign down_data  = rsp_ff;

   assign span = $signed({1'b0, max_ticks}) - $signed({1'b0, min_ticks});

   always_comb begin
      for (int l = 0; l < fasp_pkg::LANES; l++) begin
         if (up_lanes[l].acc > fasp_pkg::ACC_LIM) begin
            acc_c[l] = fasp_pkg::ACC_LIM;
         end else if (up_lanes[l].acc < -fasp_pkg::ACC_LIM) begin
            acc_c[l] = -fasp_pkg::ACC_LIM;
         end else begin
            acc_c[l] = up_lanes[l].acc;
         end
         case (up_lanes[l].quad)
            2'sb01:  z_full[l] = acc_c[l] + fasp_pkg::ACC_HALF_TURN;
            2'sb11:  z_full[l] = acc_c[l] - fasp_pkg::ACC_HALF_TURN;
            default: z_full[l] = acc_c[l];
         endcase
         z_round[l] = (z_full[l] + fasp_pkg::ROUND_HALF) >>> fasp_pkg::ROUND_SHIFT;
         ang[l]     = up_lanes[l].zero ? '0 : z_round[l][fasp_pkg::ANG_W-1:0];
         if (ang[l] > fasp_pkg::ANG_90) begin
            ang_c[l] = fasp_pkg::ANG_70;
         end else if (ang[l] < -fasp_pkg::ANG_90) begin
            ang_c[l] = -fasp_pkg::ANG_70;
         end else begin
            ang_c[l] = ang[l];
         end
         t_wide[l]  = ang_c[l] + fasp_pkg::ANG_90;
         t_val[l]   = t_wide[l][fasp_pkg::T_W-1:0];
         prod_in[l] = fasp_pkg::PROD_W'(span) * fasp_pkg::PROD_W'(t_val[l]);

         q_sum[l]  = (prod_ff[l] >>> fasp_pkg::DIV_SHIFT) + fasp_pkg::Q_OFFSET;
         q_val[l]  = q_sum[l][fasp_pkg::Q_W-1:0];
         div_in[l] = fasp_pkg::MAP_PROD_W'(q_val[l]) * fasp_pkg::MAP_PROD_W'(fasp_pkg::RECIP);

         // quotient minus the offset of 2^16 vanishes in the 16-bit sum
         ticks[l] = min_ticks + div_ff[l][fasp_pkg::RECIP_SHIFT +: fasp_pkg::TICK_W];
      end
      rsp_in = '{fin_a_ticks: ticks[0], fin_b_ticks: ticks[1],
                 fin_c_ticks: ticks[2], fin_d_ticks: ticks[3]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && stage_ready[0]) begin
         prod_ff <= prod_in;
      end
      if (valid_ff[0] && stage_ready[1]) begin
         div_ff <= div_in;
      end
      if (valid_ff[1] && stage_ready[2]) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== src/fasp_checker.sv =====
// ----------------------------------------------------------------------------
// fasp_checker
// Port-level checks on the fin angle to servo pulse core: transaction
// bookkeeping, back-pressure behavior and reset.
// ----------------------------------------------------------------------------
module fasp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input fasp_pkg::rsp_type rsp_data
);

   logic [fasp_pkg::CNT_W-1:0] outstanding_ff;
   logic [fasp_pkg::CNT_W-1:0] outstanding_in;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_valid && req_ready) begin
         outstanding_in = outstanding_in + 1'b1;
      end
      if (rsp_valid && rsp_ready) begin
         outstanding_in = outstanding_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled while result side drains");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed or dropped");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outstanding_ff != '0))
      else $error("result without an accepted transaction");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= fasp_pkg::CNT_W'(fasp_pkg::PIPE_DEPTH))
      else $error("more transactions in flight than pipeline stages");

endmodule

bind fin_angle_to_servo_pulse_core fasp_checker u_fasp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
